// File: rtl/gcg_pkg.sv
package gcg_pkg;

	localparam int ANGLE_FRAC_BITS   = 30;
	localparam int CORDIC_ITERATIONS = 24;

	localparam int LAT_W      = 28;
	localparam int LON_W      = 29;
	localparam int TAG_W      = 32;
	localparam int DIST_W     = 25;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 29;

	// angle in microdegrees after the longitude difference
	localparam int ANG_W = 30;
	// rotation datapath, accumulated angle, vectoring datapath, product terms
	localparam int CW = 34;
	localparam int ZW = 34;
	localparam int VW = 36;
	localparam int TW = 36;
	localparam int SQ_IN_W  = 63;
	localparam int SQ_OUT_W = 32;

	localparam logic [63:0] PI_Q61      = 64'h6487ED5110B4611A;
	localparam logic [63:0] UDEG_180_64 = 64'd180000000;
	localparam logic [63:0] RAD_Q0      = PI_Q61 / UDEG_180_64;
	localparam logic [63:0] RAD_R0      = PI_Q61 % UDEG_180_64;

	localparam logic [DIST_W-1:0] HALF_CIRC_M  = 25'd20015087;
	localparam logic [DIST_W-1:0] RADIUS_RESET = 25'd50000;
	localparam logic [22:0]       EARTH_R_M    = 23'd6371000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REF_LAT = 2'd0,
		CFG_REF_LON = 2'd1,
		CFG_RADIUS  = 2'd2
	} cfg_idx_t;

	// shift-subtract long division, only for elaboration
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic signed [63:0] mul_shift64(input logic signed [63:0] a,
			input logic signed [63:0] b, input int s);
		logic neg;
		logic [63:0] ua;
		logic [63:0] ub;
		logic [127:0] p;
		neg = (a < 0) != (b < 0);
		ua = a[63] ? 64'(-a) : 64'(a);
		ub = b[63] ? 64'(-b) : 64'(b);
		p = {64'd0, ua} * {64'd0, ub};
		p = p + (128'd1 << (s - 1));
		p = p >> s;
		return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
	endfunction

	// atan(2^-i) with 61 fraction bits from the power series
	function automatic logic [63:0] atan_q61(input int i);
		logic [63:0] v;
		logic [63:0] term;
		int e;
		v = '0;
		if (i == 0) begin
			v = PI_Q61 >> 2;
		end else begin
			for (int k = 0; k < 32; k++) begin
				e = i * (2 * k + 1);
				if (e <= 61) begin
					term = udiv64(64'd1 << (61 - e), 64'(2 * k + 1));
					if (k[0])
						v = v - term;
					else
						v = v + term;
				end
			end
		end
		return v;
	endfunction

	function automatic logic [ZW-1:0] atan_q(input int i);
		logic [63:0] v;
		v = atan_q61(i);
		return ZW'((v + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS));
	endfunction

	function automatic logic [CW-1:0] inv_gain_q(input int n);
		logic [63:0] p;
		logic signed [63:0] y;
		logic signed [63:0] y2;
		logic signed [63:0] t;
		logic signed [63:0] three;
		p = 64'd1 << 61;
		three = 64'sh6000000000000000;
		for (int i = 0; i < n; i++) begin
			if (2 * i <= 61)
				p = p + (p >> (2 * i));
		end
		// newton steps toward 1/sqrt(p)
		y = 64'sh1333333333333333;
		for (int k = 0; k < 8; k++) begin
			y2 = mul_shift64(y, y, 61);
			t = three - mul_shift64($signed(p), y2, 61);
			y = mul_shift64(y, t, 62);
		end
		return CW'((64'(y) + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS));
	endfunction

	// pi / 180e6 with 88 fraction bits
	function automatic logic [63:0] rad_q88_f();
		logic [63:0] q;
		logic [63:0] r;
		q = RAD_Q0;
		r = RAD_R0;
		for (int k = 0; k < 27; k++) begin
			r = r << 1;
			q = q << 1;
			if (r >= UDEG_180_64) begin
				r = r - UDEG_180_64;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	localparam logic [63:0] RAD_Q88 = rad_q88_f();
	localparam logic [30:0] RAD_HI  = RAD_Q88[62:32];
	localparam logic [31:0] RAD_LO  = RAD_Q88[31:0];

endpackage

// File: rtl/gcg_sincos.sv
module gcg_sincos #(
	parameter int ITER = gcg_pkg::CORDIC_ITERATIONS
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [gcg_pkg::ANG_W-1:0]  angle,
	output logic signed [gcg_pkg::CW-1:0]     cos_out,
	output logic signed [gcg_pkg::CW-1:0]     sin_out
);
	import gcg_pkg::*;

	localparam logic signed [ANG_W-1:0] D360 = ANG_W'(360000000);
	localparam logic signed [ANG_W-1:0] D180 = ANG_W'(180000000);
	localparam logic signed [ANG_W-1:0] D90  = ANG_W'(90000000);
	localparam logic signed [CW-1:0]    INV_GAIN = inv_gain_q(ITER);

	logic signed [ANG_W-1:0] a1, a2, f2;
	logic                    neg2;
	logic signed [ANG_W-1:0] ang_s1;
	logic [26:0]             mag_s2;
	logic                    sgn_s2, neg_s2;
	logic [57:0]             ph_s3;
	logic [58:0]             pl_s3;
	logic                    sgn_s3, neg_s3;
	logic [90:0]             zsum;
	logic [ZW-1:0]           zmag;

	logic signed [CW-1:0] cx_s [0:ITER];
	logic signed [CW-1:0] cy_s [0:ITER];
	logic signed [ZW-1:0] cz_s [0:ITER];
	logic                 cn_s [0:ITER];

	// reduce modulo a full turn into (-180, 180]
	always_comb begin
		if (angle >= D360)
			a1 = angle - D360;
		else if (angle <= -D360)
			a1 = angle + D360;
		else
			a1 = angle;
		if (a1 > D180)
			a2 = a1 - D360;
		else if (a1 <= -D180)
			a2 = a1 + D360;
		else
			a2 = a1;
	end

	// fold into [-90, 90], sign of both outputs flips
	always_comb begin
		if (ang_s1 > D90) begin
			f2 = ang_s1 - D180;
			neg2 = 1'b1;
		end else if (ang_s1 < -D90) begin
			f2 = ang_s1 + D180;
			neg2 = 1'b1;
		end else begin
			f2 = ang_s1;
			neg2 = 1'b0;
		end
	end

	assign zsum = {ph_s3, 32'd0} + 91'(pl_s3) + (91'd1 << 57);
	assign zmag = ZW'(zsum[88:58]);

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= a2;
			mag_s2 <= f2[ANG_W-1] ? 27'(-f2) : 27'(f2);
			sgn_s2 <= f2[ANG_W-1];
			neg_s2 <= neg2;
			ph_s3  <= 58'(mag_s2) * 58'(RAD_HI);
			pl_s3  <= 59'(mag_s2) * 59'(RAD_LO);
			sgn_s3 <= sgn_s2;
			neg_s3 <= neg_s2;
			cx_s[0] <= INV_GAIN;
			cy_s[0] <= '0;
			cz_s[0] <= sgn_s3 ? -$signed(zmag) : $signed(zmag);
			cn_s[0] <= neg_s3;
			cos_out <= cn_s[ITER] ? -cx_s[ITER] : cx_s[ITER];
			sin_out <= cn_s[ITER] ? -cy_s[ITER] : cy_s[ITER];
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_rot
		localparam logic signed [ZW-1:0] ATAN_I = atan_q(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (cz_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - ATAN_I;
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + ATAN_I;
				end
				cn_s[i+1] <= cn_s[i];
			end
		end
	end

endmodule

// File: rtl/gcg_isqrt.sv
module gcg_isqrt (
	input  logic                           clk,
	input  logic                           en,
	input  logic [gcg_pkg::SQ_IN_W-1:0]    radicand,
	output logic [gcg_pkg::SQ_OUT_W-1:0]   root
);
	import gcg_pkg::*;

	localparam int STEPS = SQ_OUT_W;

	logic [63:0] rem_s [0:STEPS-1];
	logic [63:0] r_s   [0:STEPS-1];

	// one result bit per stage, restoring recurrence
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [63:0] BIT_K = 64'd1 << (2 * (STEPS - 1 - k));
		logic [63:0] rem_in, r_in, trial;
		if (k == 0) begin : g_first
			assign rem_in = 64'(radicand);
			assign r_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign r_in   = r_s[k-1];
		end
		assign trial = r_in + BIT_K;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					r_s[k]   <= (r_in >> 1) + BIT_K;
				end else begin
					rem_s[k] <= rem_in;
					r_s[k]   <= r_in >> 1;
				end
			end
		end
	end

	assign root = r_s[STEPS-1][SQ_OUT_W-1:0];

endmodule

// File: rtl/great_circle_geofence_check.sv
// throughput: one word per cycle while no result word is stalled; the path is three sine/cosine pipelines,
// four product and clamp stages, two 32-stage square roots, one vectoring cordic
// pipeline and two distance stages
// a stalled result word freezes every stage and stalls the input side
// reset clears all valid bits and loads reference 0,0 and radius 50000 m
module great_circle_geofence_check #(
	parameter int ITER = gcg_pkg::CORDIC_ITERATIONS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [gcg_pkg::LAT_W-1:0]       point_lat_udeg,
	input  logic signed [gcg_pkg::LON_W-1:0]       point_lon_udeg,
	input  logic [gcg_pkg::TAG_W-1:0]              point_tag,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [gcg_pkg::TAG_W-1:0]              tag_out,
	output logic [gcg_pkg::DIST_W-1:0]             distance_m,
	output logic                                   within_radius,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [gcg_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [gcg_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import gcg_pkg::*;

	localparam int LAT = 2 * ITER + 43;
	localparam logic signed [31:0] ONE = 32'sd1 << ANGLE_FRAC_BITS;

	logic adv;

	logic signed [LAT_W-1:0] ref_lat_q;
	logic signed [LON_W-1:0] ref_lon_q;
	logic [DIST_W-1:0]       radius_q;

	logic [LAT-1:0]   vld_s;
	logic [TAG_W-1:0] tag_s [0:LAT-1];

	logic signed [ANG_W-1:0] ang_ref, ang_pt, ang_dl;
	logic signed [CW-1:0]    c1, s1, c2, s2, cd;

	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lat_q <= '0;
			ref_lon_q <= '0;
			radius_q  <= RADIUS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_REF_LAT: ref_lat_q <= $signed(cfg_data[LAT_W-1:0]);
				CFG_REF_LON: ref_lon_q <= $signed(cfg_data[LON_W-1:0]);
				CFG_RADIUS:  radius_q  <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[LAT-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[0] <= point_tag;
			for (int k = 1; k < LAT; k++)
				tag_s[k] <= tag_s[k-1];
		end
	end

	assign ang_ref = ANG_W'(ref_lat_q);
	assign ang_pt  = ANG_W'(point_lat_udeg);
	assign ang_dl  = ANG_W'(point_lon_udeg) - ANG_W'(ref_lon_q);

	gcg_sincos #(.ITER(ITER)) u_sc_ref (
		.clk(clk), .en(adv), .angle(ang_ref), .cos_out(c1), .sin_out(s1));
	gcg_sincos #(.ITER(ITER)) u_sc_pt (
		.clk(clk), .en(adv), .angle(ang_pt), .cos_out(c2), .sin_out(s2));
	gcg_sincos #(.ITER(ITER)) u_sc_dl (
		.clk(clk), .en(adv), .angle(ang_dl), .cos_out(cd), .sin_out());

	// law of cosines: c = s1*s2 + (c1*c2)*cd, each product rounded to nearest, ties away from zero
	logic [CW-1:0]        as1, as2, ac1, ac2;
	logic [2*CW-1:0]      pa_m1, pb_m1;
	logic                 na_m1, nb_m1;
	logic signed [CW-1:0] cd_m1, cd_m2;
	logic [2*CW-1:0]      ra, rb;
	logic [TW-1:0]        qa, qb;
	logic signed [TW-1:0] t1_m2, t2_m2, t1_m3;
	logic [TW-1:0]        at2;
	logic [CW-1:0]        acd;
	logic [TW+CW-1:0]     pc_m3, rc;
	logic                 nc_m3;
	logic [TW-1:0]        qc;
	logic signed [TW-1:0] sc;
	logic signed [TW:0]   csum;
	logic signed [31:0]   cl;
	logic signed [32:0]   um, vm;
	logic [SQ_IN_W-1:0]   u_m4, v_m4;

	assign as1 = s1[CW-1] ? CW'(-s1) : CW'(s1);
	assign as2 = s2[CW-1] ? CW'(-s2) : CW'(s2);
	assign ac1 = c1[CW-1] ? CW'(-c1) : CW'(c1);
	assign ac2 = c2[CW-1] ? CW'(-c2) : CW'(c2);
	assign ra  = pa_m1 + ((2*CW)'(1) << (ANGLE_FRAC_BITS - 1));
	assign rb  = pb_m1 + ((2*CW)'(1) << (ANGLE_FRAC_BITS - 1));
	assign qa  = TW'(ra >> ANGLE_FRAC_BITS);
	assign qb  = TW'(rb >> ANGLE_FRAC_BITS);
	assign at2 = t2_m2[TW-1] ? TW'(-t2_m2) : TW'(t2_m2);
	assign acd = cd_m2[CW-1] ? CW'(-cd_m2) : CW'(cd_m2);
	assign rc  = pc_m3 + ((TW+CW)'(1) << (ANGLE_FRAC_BITS - 1));
	assign qc  = TW'(rc >> ANGLE_FRAC_BITS);
	assign sc  = nc_m3 ? -$signed(qc) : $signed(qc);
	assign csum = (TW+1)'(t1_m3) + (TW+1)'(sc);

	always_comb begin
		if (csum > (TW+1)'(ONE))
			cl = ONE;
		else if (csum < -(TW+1)'(ONE))
			cl = -ONE;
		else
			cl = 32'(csum);
		um = 33'(ONE) - 33'(cl);
		vm = 33'(ONE) + 33'(cl);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_m1 <= (2*CW)'(as1) * (2*CW)'(as2);
			pb_m1 <= (2*CW)'(ac1) * (2*CW)'(ac2);
			na_m1 <= s1[CW-1] != s2[CW-1];
			nb_m1 <= c1[CW-1] != c2[CW-1];
			cd_m1 <= cd;
			t1_m2 <= na_m1 ? -$signed(qa) : $signed(qa);
			t2_m2 <= nb_m1 ? -$signed(qb) : $signed(qb);
			cd_m2 <= cd_m1;
			pc_m3 <= (TW+CW)'(at2) * (TW+CW)'(acd);
			nc_m3 <= t2_m2[TW-1] != cd_m2[CW-1];
			t1_m3 <= t1_m2;
			u_m4  <= {um[31:0], 31'd0};
			v_m4  <= {vm[31:0], 31'd0};
		end
	end

	logic [SQ_OUT_W-1:0] sq_u, sq_v;

	gcg_isqrt u_sq_u (.clk(clk), .en(adv), .radicand(u_m4), .root(sq_u));
	gcg_isqrt u_sq_v (.clk(clk), .en(adv), .radicand(v_m4), .root(sq_v));

	// vectoring cordic: atan2(sqrt(1-c), sqrt(1+c)) is half the central angle
	logic signed [VW-1:0] vx_s [0:ITER-1];
	logic signed [VW-1:0] vy_s [0:ITER-1];
	logic signed [ZW-1:0] vz_s [0:ITER-1];

	for (genvar i = 0; i < ITER; i++) begin : g_vec
		localparam logic signed [ZW-1:0] ATAN_I = atan_q(i);
		logic signed [VW-1:0] xi, yi;
		logic signed [ZW-1:0] zi;
		if (i == 0) begin : g_first
			assign xi = $signed(VW'(sq_v));
			assign yi = $signed(VW'(sq_u));
			assign zi = '0;
		end else begin : g_next
			assign xi = vx_s[i-1];
			assign yi = vy_s[i-1];
			assign zi = vz_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (yi >= 0) begin
					vx_s[i] <= xi + (yi >>> i);
					vy_s[i] <= yi - (xi >>> i);
					vz_s[i] <= zi + ATAN_I;
				end else begin
					vx_s[i] <= xi - (yi >>> i);
					vy_s[i] <= yi + (xi >>> i);
					vz_s[i] <= zi - ATAN_I;
				end
			end
		end
	end

	logic [ZW-1:0]   theta;
	logic [ZW+22:0]  prod_d1, rd;
	logic [26:0]     qd;
	logic [DIST_W-1:0] dist_c;
	logic [DIST_W-1:0] dist_d2;
	logic              within_d2;

	assign theta  = vz_s[ITER-1][ZW-1] ? '0 : {vz_s[ITER-1][ZW-2:0], 1'b0};
	assign rd     = prod_d1 + ((ZW+23)'(1) << (ANGLE_FRAC_BITS - 1));
	assign qd     = 27'(rd >> ANGLE_FRAC_BITS);
	assign dist_c = (qd > 27'(HALF_CIRC_M)) ? HALF_CIRC_M : qd[DIST_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_d1   <= (ZW+23)'(theta) * (ZW+23)'(EARTH_R_M);
			dist_d2   <= dist_c;
			within_d2 <= dist_c <= radius_q;
		end
	end

	assign out_valid     = vld_s[LAT-1];
	assign tag_out       = tag_s[LAT-1];
	assign distance_m    = dist_d2;
	assign within_radius = within_d2;

endmodule

// File: rtl/gcg_checker.sv
module gcg_assertions (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [gcg_pkg::TAG_W-1:0]         tag_out,
	input logic [gcg_pkg::DIST_W-1:0]        distance_m,
	input logic                              within_radius
);
	import gcg_pkg::*;

	// a stalled result word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(tag_out) && $stable(distance_m)
			&& $stable(within_radius))
		else $error("stalled result word changed");

	// input side only backs up behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	a_dist_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_m <= HALF_CIRC_M)
		else $error("distance beyond half circumference");

endmodule

bind great_circle_geofence_check gcg_assertions u_gcg_assertions (.*);
